// ----- design/html_entity_decode_tag_strip_defines.svh -----
// ----------------------------------------------------------------------------
// html entity decode assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef HTML_ENTITY_DECODE_TAG_STRIP_DEFINES_SVH
`define HTML_ENTITY_DECODE_TAG_STRIP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define HEDTS_ASSERT_IMP(LBL, CLK, RSTN, ANT, CON, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |-> (CON)) \
        else $error(MSG);
// next-cycle implication
`define HEDTS_ASSERT_NXT(LBL, CLK, RSTN, ANT, CON, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |=> (CON)) \
        else $error(MSG);
`else
`define HEDTS_ASSERT_IMP(LBL, CLK, RSTN, ANT, CON, MSG)
`define HEDTS_ASSERT_NXT(LBL, CLK, RSTN, ANT, CON, MSG)
`endif

`endif

// ----- design/hedts_pkg.sv -----
// ----------------------------------------------------------------------------
// hedts_pkg
// shared types, character codes and the entity table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hedts_pkg;

    typedef logic [7:0] byte_t;

    localparam byte_t CH_NUL   = 8'h00;
    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_QUOT  = 8'h22;
    localparam byte_t CH_AMP   = 8'h26;
    localparam byte_t CH_APOS  = 8'h27;
    localparam byte_t CH_DASH  = 8'h2D;
    localparam byte_t CH_SEMI  = 8'h3B;
    localparam byte_t CH_LT    = 8'h3C;
    localparam byte_t CH_GT    = 8'h3E;

    localparam byte_t REPL_RESET = 8'h3F;

    localparam int ENT_COUNT   = 13;
    localparam int ENT_LEN_MAX = 7;

    // text is left aligned, first character in the top byte
    typedef struct packed {
        logic [8*ENT_LEN_MAX-1:0] text;
        logic [2:0]               len;
        byte_t                    ch;
    } entity_t;

    localparam entity_t ENT_TABLE [ENT_COUNT] = '{
        '{ {"&amp;",   16'h0}, 3'd5, CH_AMP   },
        '{ {"&#38;",   16'h0}, 3'd5, CH_AMP   },
        '{ {"&#39;",   16'h0}, 3'd5, CH_APOS  },
        '{ {"&apos;",   8'h0}, 3'd6, CH_APOS  },
        '{ "&rsquo;",          3'd7, CH_APOS  },
        '{ "&lsquo;",          3'd7, CH_APOS  },
        '{ {"&quot;",   8'h0}, 3'd6, CH_QUOT  },
        '{ "&ldquo;",          3'd7, CH_QUOT  },
        '{ "&rdquo;",          3'd7, CH_QUOT  },
        '{ {"&nbsp;",   8'h0}, 3'd6, CH_SPACE },
        '{ "&mdash;",          3'd7, CH_DASH  },
        '{ "&ndash;",          3'd7, CH_DASH  },
        '{ "&#8217;",          3'd7, CH_APOS  }
    };

    // one window slot as seen by the decision logic
    typedef struct packed {
        logic  valid;
        logic  semi;
        byte_t data;
    } cell_tap_t;

    // head decision
    typedef struct packed {
        logic  emit;
        byte_t ch;
        logic  tag;
    } decision_t;

endpackage

// ----- design/hedts_intf.sv -----
// ----------------------------------------------------------------------------
// hedts channel interfaces
// valid/ready channels for text bytes in and decoded bytes out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hedts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_value;

    modport source (output valid, output char_value, input ready);
    modport sink (input valid, input char_value, output ready);
endinterface

interface hedts_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       end_of_string;

    modport source (output valid, output out_char, output end_of_string, input ready);
    modport sink (input valid, input out_char, input end_of_string, output ready);
endinterface

// ----- design/html_entity_decode_tag_strip.sv -----
// ----------------------------------------------------------------------------
// html_entity_decode_tag_strip: entity decoder and tag stripper, one byte a beat
// a byte's result is loaded into the output register as the byte LOOKAHEAD
//   positions later is accepted; throughput one byte per cycle while the output is free
// terminator: zeros are flushed through the cell chain, then one end beat
// reset: window cells empty, tag and skip cleared, replacement char 0x3F
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "html_entity_decode_tag_strip_defines.svh"

module html_entity_decode_tag_strip #(
    parameter int LOOKAHEAD = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  hedts_pkg::byte_t cfg_write_data,
    hedts_in_if.sink         char_in,
    hedts_out_if.source      char_out
);
    import hedts_pkg::*;

    localparam int SKIP_W = $clog2(LOOKAHEAD + 1);
    localparam int CNT_W  = $clog2(LOOKAHEAD);

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_FLUSH = 3'b010,
        ST_END   = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  flush_cnt_reg, flush_cnt_next;
    logic              tag_reg, tag_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    byte_t             repl_reg, repl_next;
    logic              out_valid_reg, out_valid_next;
    byte_t             out_char_reg, out_char_next;
    logic              out_eos_reg, out_eos_next;

    logic                        out_free;
    logic                        in_fire;
    logic                        step;
    byte_t                       tail_byte;
    cell_tap_t                   tail_tap;
    cell_tap_t [LOOKAHEAD-1:0]   cell_taps;
    cell_tap_t [LOOKAHEAD:0]     window;
    logic [LOOKAHEAD-1:0]        cell_valid;
    decision_t                   dec;
    logic [SKIP_W-1:0]           dec_skip;

    // output register frees up when empty or being taken this cycle
    assign out_free      = !out_valid_reg || char_out.ready;
    assign char_in.ready = (state_reg == ST_RUN) && out_free;
    assign in_fire       = char_in.valid && char_in.ready;

    // the chain advances on every accepted nonzero byte and on every flush cycle with the output free
    assign step = (in_fire && char_in.char_value != CH_NUL) ||
                  (state_reg == ST_FLUSH && out_free);

    // the incoming byte is the last lookahead slot; zeros enter while flushing
    assign tail_byte      = (state_reg == ST_RUN) ? char_in.char_value : CH_NUL;
    assign tail_tap.valid = (tail_byte != CH_NUL);
    assign tail_tap.semi  = (tail_byte == CH_SEMI);
    assign tail_tap.data  = tail_byte;

    // row of window cells, cell 0 is the head
    for (genvar g = 0; g < LOOKAHEAD; g++)
    begin : g_cell
        if (g == LOOKAHEAD - 1)
        begin : g_last
            hedts_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (step),
                .din   (tail_tap.data),
                .tap   (cell_taps[g])
            );
        end
        else
        begin : g_mid
            hedts_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (step),
                .din   (cell_taps[g+1].data),
                .tap   (cell_taps[g])
            );
        end
        assign cell_valid[g] = cell_taps[g].valid;
    end

    assign window = {tail_tap, cell_taps};

    // head decision: skip bytes of a consumed entity, drop tag contents,
    // collapse entities, pass everything else
    hedts_decide #(
        .LOOKAHEAD (LOOKAHEAD)
    ) u_decide (
        .taps      (window),
        .tag       (tag_reg),
        .skip      (skip_reg),
        .repl      (repl_reg),
        .dec       (dec),
        .skip_next (dec_skip)
    );

    assign repl_next = cfg_write_en ? cfg_write_data : repl_reg;

    always_comb
    begin
        state_next     = state_reg;
        flush_cnt_next = flush_cnt_reg;
        tag_next       = tag_reg;
        skip_next      = skip_reg;
        out_valid_next = out_valid_reg && !char_out.ready;
        out_char_next  = out_char_reg;
        out_eos_next   = out_eos_reg;

        // at most one decided byte per step
        if (step)
        begin
            tag_next  = dec.tag;
            skip_next = dec_skip;
            if (dec.emit)
            begin
                out_valid_next = 1'b1;
                out_char_next  = dec.ch;
                out_eos_next   = 1'b0;
            end
        end

        unique case (state_reg)
            ST_RUN:
            begin
                // terminator: drain the remaining cells with short lookahead
                if (in_fire && char_in.char_value == CH_NUL)
                begin
                    state_next     = ST_FLUSH;
                    flush_cnt_next = CNT_W'(LOOKAHEAD - 1);
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    if (flush_cnt_reg == '0)
                    begin
                        state_next = ST_END;
                    end
                    else
                    begin
                        flush_cnt_next = flush_cnt_reg - CNT_W'(1);
                    end
                end
            end
            ST_END:
            begin
                // end marker beat; next string starts clean
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CH_NUL;
                    out_eos_next   = 1'b1;
                    tag_next       = 1'b0;
                    skip_next      = '0;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            flush_cnt_reg <= '0;
            tag_reg       <= 1'b0;
            skip_reg      <= '0;
            repl_reg      <= REPL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flush_cnt_reg <= flush_cnt_next;
            tag_reg       <= tag_next;
            skip_reg      <= skip_next;
            repl_reg      <= repl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_eos_reg  <= out_eos_next;
    end

    assign char_out.valid         = out_valid_reg;
    assign char_out.out_char      = out_char_reg;
    assign char_out.end_of_string = out_eos_reg;

    // checks
    `HEDTS_ASSERT_NXT(a_term_flush, clk, rst_n, in_fire && char_in.char_value == CH_NUL, state_reg == ST_FLUSH, "terminator did not start flush")
    `HEDTS_ASSERT_IMP(a_end_empty, clk, rst_n, state_reg == ST_END, cell_valid == '0, "window not empty at end marker")
    `HEDTS_ASSERT_IMP(a_fill_order, clk, rst_n, state_reg == ST_RUN && cell_taps[0].valid, cell_taps[LOOKAHEAD-1].valid, "window cells not contiguous")
    `HEDTS_ASSERT_IMP(a_skip_tag, clk, rst_n, skip_reg != '0, !tag_reg, "skip and tag active together")
    `HEDTS_ASSERT_IMP(a_eos_zero, clk, rst_n, out_valid_reg && out_eos_reg, out_char_reg == CH_NUL, "end marker beat carries nonzero byte")

endmodule

// ----- design/hedts_cell.sv -----
// ----------------------------------------------------------------------------
// hedts_cell
// one byte slot of the lookahead window, shifts toward the head
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hedts_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift,
    input  hedts_pkg::byte_t   din,
    output hedts_pkg::cell_tap_t tap
);
    import hedts_pkg::*;

    byte_t data_reg;
    byte_t data_next;

    assign data_next = shift ? din : data_reg;

    // zero means empty slot, real text bytes are never zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= CH_NUL;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign tap.valid = (data_reg != CH_NUL);
    assign tap.semi  = (data_reg == CH_SEMI);
    assign tap.data  = data_reg;

endmodule

// ----- design/hedts_decide.sv -----
// ----------------------------------------------------------------------------
// hedts_decide
// decides the fate of the byte at the head of the window
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hedts_decide #(
    parameter int  LOOKAHEAD = 8,
    localparam int SKIP_W    = $clog2(LOOKAHEAD + 1)
) (
    input  hedts_pkg::cell_tap_t [LOOKAHEAD:0] taps,
    input  logic                               tag,
    input  logic [SKIP_W-1:0]                  skip,
    input  hedts_pkg::byte_t                   repl,
    output hedts_pkg::decision_t               dec,
    output logic [SKIP_W-1:0]                  skip_next
);
    import hedts_pkg::*;

    logic              semi_hit;
    logic [SKIP_W-1:0] semi_pos;
    logic              ent_hit;
    byte_t             ent_ch;

    // first semicolon past the head
    always_comb
    begin
        semi_hit = 1'b0;
        semi_pos = '0;
        for (int p = LOOKAHEAD; p >= 1; p--)
        begin
            if (taps[p].semi)
            begin
                semi_hit = 1'b1;
                semi_pos = SKIP_W'(p);
            end
        end
    end

    // fixed entity compare, empty slots read as zero and never match
    always_comb
    begin
        logic m;
        m       = 1'b0;
        ent_hit = 1'b0;
        ent_ch  = CH_NUL;
        for (int e = ENT_COUNT - 1; e >= 0; e--)
        begin
            m = 1'b1;
            for (int i = 0; i < ENT_LEN_MAX; i++)
            begin
                if (i < int'(ENT_TABLE[e].len) &&
                    taps[i].data != ENT_TABLE[e].text[8*(ENT_LEN_MAX-1-i) +: 8])
                begin
                    m = 1'b0;
                end
            end
            if (m)
            begin
                ent_hit = 1'b1;
                ent_ch  = ENT_TABLE[e].ch;
            end
        end
    end

    // an entity always ends at its first semicolon, so both cases skip semi_pos
    always_comb
    begin
        dec.emit  = 1'b0;
        dec.ch    = taps[0].data;
        dec.tag   = tag;
        skip_next = skip;
        if (taps[0].valid)
        begin
            priority if (skip != '0)
            begin
                skip_next = skip - SKIP_W'(1);
            end
            else if (tag)
            begin
                if (taps[0].data == CH_GT)
                begin
                    dec.tag = 1'b0;
                end
            end
            else if (taps[0].data == CH_LT)
            begin
                dec.tag = 1'b1;
            end
            else if (taps[0].data == CH_AMP && semi_hit)
            begin
                dec.emit  = 1'b1;
                dec.ch    = ent_hit ? ent_ch : repl;
                skip_next = semi_pos;
            end
            else
            begin
                dec.emit = 1'b1;
            end
        end
    end

endmodule

// ----- bench/html_entity_decode_tag_strip_tb.sv -----
// ----------------------------------------------------------------------------
// html_entity_decode_tag_strip_tb: self-checking bench for the entity decoder
// drives text strings through the valid/ready input, predicts every decoded
// beat from its own copy of the window, tag flag and replacement char, and
// compares each output beat in order; random bursts, stalls and a long hold
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module html_entity_decode_tag_strip_tb;
    import hedts_pkg::*;

    localparam int LOOKAHEAD     = 8;
    localparam int WIN_DEPTH     = LOOKAHEAD + 1;
    localparam int RANDOM_ITEMS  = 300;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = LOOKAHEAD + 4;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int MAX_PRINTS    = 40;

    // receiver behavior outside the long hold-off
    typedef enum int { RX_FREE, RX_RANDOM, RX_PATTERN } rx_style_t;

    // one expected output beat
    typedef struct packed {
        byte_t ch;
        logic  eos;
    } decoded_beat_t;

    logic  clk;
    logic  rst_n;
    logic  cfg_write_en;
    byte_t cfg_write_data;

    hedts_in_if  char_if ();
    hedts_out_if dec_if ();

    html_entity_decode_tag_strip #(
        .LOOKAHEAD(LOOKAHEAD)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .char_in       (char_if),
        .char_out      (dec_if)
    );

    // ------------------------------------------------------------------
    // predictor state: lookahead window, tag flag, replacement char
    // ------------------------------------------------------------------
    byte_t         win_bytes [WIN_DEPTH];
    int            win_fill;
    logic          in_markup;
    byte_t         repl_char;
    decoded_beat_t expected_q [$];

    // known entities in priority order, first match wins
    string ent_text [ENT_COUNT] = '{
        "&amp;", "&#38;", "&#39;", "&apos;", "&rsquo;", "&lsquo;", "&quot;",
        "&ldquo;", "&rdquo;", "&nbsp;", "&mdash;", "&ndash;", "&#8217;"
    };
    byte_t ent_char [ENT_COUNT] = '{
        CH_AMP, CH_AMP, CH_APOS, CH_APOS, CH_APOS, CH_APOS, CH_QUOT,
        CH_QUOT, CH_QUOT, CH_SPACE, CH_DASH, CH_DASH, CH_APOS
    };

    // stimulus and bookkeeping
    byte_t     string_bytes [$];
    int        items_sent;
    int        burst_left;
    logic      gaps_on;
    rx_style_t rx_style;
    logic      hold_req;
    int        mismatch_count;
    int        cycle_count;

    initial
    begin
        mismatch_count = 0;
        cycle_count    = 0;
        burst_left     = 0;
        items_sent     = 0;
        hold_req       = 1'b0;
    end

    // ------------------------------------------------------------------
    // decoder prediction
    // ------------------------------------------------------------------
    function automatic void push_decoded(byte_t ch, logic eos);
        decoded_beat_t beat;
        beat.ch  = ch;
        beat.eos = eos;
        expected_q.push_back(beat);
    endfunction

    function automatic void clear_window();
        int k;
        for (k = 0; k < WIN_DEPTH; k++)
            win_bytes[k] = CH_NUL;
        win_fill  = 0;
        in_markup = 1'b0;
    endfunction

    // drop n bytes from the head, zero fill at the tail
    function automatic void shift_out(int n);
        int k;
        if (n > win_fill)
            n = win_fill;
        for (k = 0; k < WIN_DEPTH; k++)
            win_bytes[k] = (k + n < WIN_DEPTH) ? win_bytes[k + n] : CH_NUL;
        win_fill -= n;
    endfunction

    // index of the first known entity at the head, -1 if none
    function automatic int match_entity_at_head();
        int   e;
        int   i;
        int   len;
        logic ok;
        for (e = 0; e < ENT_COUNT; e++)
        begin
            len = ent_text[e].len();
            ok  = (len <= win_fill);
            for (i = 0; ok && i < len; i++)
                if (win_bytes[i] != byte_t'(ent_text[e][i]))
                    ok = 1'b0;
            if (ok)
                return e;
        end
        return -1;
    endfunction

    // decide heads; with need_full set, non-tag heads only while the window is full
    function automatic void decide_heads(logic need_full);
        byte_t b;
        int    e;
        int    pos;
        int    semi;
        logic  busy;
        busy = 1'b1;
        while (busy && win_fill > 0)
        begin
            b = win_bytes[0];
            if (in_markup)
            begin
                // tag bytes vanish even before the window fills
                shift_out(1);
                if (b == CH_GT)
                    in_markup = 1'b0;
            end
            else if (need_full && win_fill < WIN_DEPTH)
            begin
                busy = 1'b0;
            end
            else if (b == CH_LT)
            begin
                in_markup = 1'b1;
                shift_out(1);
            end
            else
            begin
                e    = (b == CH_AMP) ? match_entity_at_head() : -1;
                semi = 0;
                if (b == CH_AMP && e < 0)
                    for (pos = 1; pos < win_fill && semi == 0; pos++)
                        if (win_bytes[pos] == CH_SEMI)
                            semi = pos;
                if (e >= 0)
                begin
                    push_decoded(ent_char[e], 1'b0);
                    shift_out(ent_text[e].len());
                end
                else if (semi != 0 && semi <= LOOKAHEAD)
                begin
                    // unknown entity closed within the lookahead
                    push_decoded(repl_char, 1'b0);
                    shift_out(semi + 1);
                end
                else
                begin
                    push_decoded(b, 1'b0);
                    shift_out(1);
                end
            end
        end
    endfunction

    function automatic void predict_char(byte_t v);
        if (v != CH_NUL)
        begin
            if (win_fill < WIN_DEPTH)
            begin
                win_bytes[win_fill] = v;
                win_fill++;
            end
            decide_heads(1'b1);
        end
        else
        begin
            // terminator: flush what is held, then the end marker
            decide_heads(1'b0);
            push_decoded(CH_NUL, 1'b1);
            clear_window();
        end
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("[cycle %0d] decode error: %s", cycle_count, msg);
    endtask

    task automatic check_beat(byte_t ch, logic eos);
        decoded_beat_t want;
        if (expected_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected beat char 0x%02h eos %0b", ch, eos));
        end
        else
        begin
            want = expected_q.pop_front();
            if (ch !== want.ch)
                report_mismatch($sformatf("out_char 0x%02h, wanted 0x%02h", ch, want.ch));
            if (eos !== want.eos)
                report_mismatch($sformatf("end_of_string %0b, wanted %0b", eos, want.eos));
        end
    endtask

    // input beats are predicted before output beats of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (char_if.valid && char_if.ready)
                predict_char(char_if.char_value);
            if (dec_if.valid && dec_if.ready)
                check_beat(dec_if.out_char, dec_if.end_of_string);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // clock and receiver
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: own stall pattern, plus a long hold-off on request
    initial
    begin : rx_side
        int hold_left;
        int rx_phase;
        hold_left = 0;
        rx_phase  = 0;
        dec_if.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                dec_if.ready <= 1'b0;
            end
            else
            begin
                case (rx_style)
                    RX_FREE:    dec_if.ready <= 1'b1;
                    RX_RANDOM:  dec_if.ready <= ($urandom_range(0, 99) >= 35);
                    RX_PATTERN: dec_if.ready <= ((rx_phase % 5) != 0) && ((rx_phase % 11) > 2);
                    default:    dec_if.ready <= 1'b1;
                endcase
            end
            rx_phase++;
        end
    end

    // ------------------------------------------------------------------
    // sender side, all changes at the falling edge
    // ------------------------------------------------------------------
    task automatic send_char(byte_t v);
        char_if.valid      <= 1'b1;
        char_if.char_value <= v;
        @(posedge clk);
        while (!char_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle(int n);
        char_if.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // send the whole string queue, terminator included, in bursts
    task automatic send_text();
        int k;
        for (k = 0; k < string_bytes.size(); k++)
        begin
            if (gaps_on && burst_left == 0)
            begin
                idle($urandom_range(1, 6));
                burst_left = $urandom_range(1, 16);
            end
            if (burst_left > 0)
                burst_left--;
            send_char(string_bytes[k]);
        end
        items_sent += string_bytes.size();
    endtask

    // stop sending until every expected beat is back, then let it settle
    task automatic wait_drain();
        char_if.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // only called with the window empty, right after a drain
    task automatic write_repl(byte_t v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        repl_char = v;
    endtask

    // ------------------------------------------------------------------
    // string building
    // ------------------------------------------------------------------
    function automatic void append_text(string s);
        int k;
        for (k = 0; k < s.len(); k++)
            string_bytes.push_back(byte_t'(s[k]));
    endfunction

    function automatic byte_t random_letter();
        return byte_t'(8'h61 + $urandom_range(0, 25));
    endfunction

    function automatic byte_t random_text_byte();
        return byte_t'($urandom_range(1, 255));
    endfunction

    function automatic void add_fragment();
        int    kind;
        int    n;
        int    e;
        int    p;
        int    k;
        byte_t b;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1:
            begin
                n = $urandom_range(1, 4);
                repeat (n) string_bytes.push_back(random_text_byte());
            end
            2, 3:
            begin
                e = $urandom_range(0, ENT_COUNT - 1);
                append_text(ent_text[e]);
            end
            4:
            begin
                // unknown entity, semicolon from just inside to past the lookahead
                string_bytes.push_back(CH_AMP);
                n = $urandom_range(0, 10);
                repeat (n) string_bytes.push_back(random_letter());
                string_bytes.push_back(CH_SEMI);
            end
            5:
            begin
                string_bytes.push_back(CH_LT);
                n = $urandom_range(0, 6);
                for (k = 0; k < n; k++)
                begin
                    b = random_text_byte();
                    string_bytes.push_back((b == CH_GT) ? random_letter() : b);
                end
                string_bytes.push_back(CH_GT);
            end
            6:
            begin
                // near miss: one byte off, or the closing semicolon missing
                e = $urandom_range(0, ENT_COUNT - 1);
                n = ent_text[e].len();
                p = $urandom_range(1, n - 2);
                for (k = 0; k < n; k++)
                begin
                    if (k == p)
                        string_bytes.push_back(random_letter());
                    else if (k < n - 1 || $urandom_range(0, 1))
                        string_bytes.push_back(byte_t'(ent_text[e][k]));
                end
            end
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       string_bytes.push_back(CH_AMP);
                    1:       string_bytes.push_back(CH_LT);
                    2:       string_bytes.push_back(CH_GT);
                    default: string_bytes.push_back(CH_SEMI);
                endcase
            end
            8:
            begin
                n = $urandom_range(1, 10);
                repeat (n) string_bytes.push_back(random_letter());
            end
            default:
            begin
                n = $urandom_range(1, 8);
                repeat (n) string_bytes.push_back(random_text_byte());
            end
        endcase
    endfunction

    // one random string with terminator; some strings are pure noise
    function automatic void build_random_text();
        int n;
        string_bytes.delete();
        if ($urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 20);
            repeat (n) string_bytes.push_back(random_text_byte());
        end
        else
        begin
            n = $urandom_range(0, 5);
            repeat (n) add_fragment();
        end
        string_bytes.push_back(CH_NUL);
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // empty string, then a known entity decided during the flush
    task automatic test_empty_and_known_entity();
        string_bytes.delete();
        string_bytes.push_back(CH_NUL);
        send_text();
        string_bytes.delete();
        append_text("&amp;");
        string_bytes.push_back(CH_NUL);
        send_text();
    endtask

    // extreme byte values, a stripped tag, an unknown entity at reset replacement
    task automatic test_tag_and_unknown_entity();
        string_bytes.delete();
        string_bytes.push_back(8'hFF);
        append_text("<b>");
        string_bytes.push_back(8'h01);
        append_text("&q;");
        string_bytes.push_back(CH_NUL);
        send_text();
    endtask

    // entity cut off by the terminator, tag never closed
    task automatic test_truncated_tail();
        string_bytes.delete();
        append_text("&nb");
        string_bytes.push_back(CH_NUL);
        send_text();
        string_bytes.delete();
        append_text("<ab");
        string_bytes.push_back(CH_NUL);
        send_text();
    endtask

    // phases of random strings, each with its own replacement char and pacing
    task automatic test_random_text();
        int phase;
        int s;
        phase      = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            wait_drain();
            case (phase)
                0:       write_repl(8'h00);
                1:       write_repl(8'hFF);
                default: write_repl(byte_t'($urandom_range(0, 255)));
            endcase
            rx_style = rx_style_t'(phase % 3);
            gaps_on  = ((phase % 6) != 3);
            for (s = 0; s < 4; s++)
            begin
                build_random_text();
                send_text();
            end
            phase++;
        end
    endtask

    // receiver holds off while the sender keeps offering, block must back up
    task automatic test_output_hold_off();
        int n;
        wait_drain();
        rx_style = RX_RANDOM;
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        string_bytes.delete();
        for (n = 0; n < 40; n++)
            string_bytes.push_back(random_letter());
        append_text("&mdash;&zz;");
        string_bytes.push_back(CH_NUL);
        send_text();
        wait_drain();
    endtask

    initial
    begin
        char_if.valid      <= 1'b0;
        char_if.char_value <= CH_NUL;
        cfg_write_en       <= 1'b0;
        cfg_write_data     <= CH_NUL;
        rst_n              <= 1'b0;
        clear_window();
        repl_char = REPL_RESET;
        rx_style  = RX_RANDOM;
        gaps_on   = 1'b1;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_and_known_entity();
        test_tag_and_unknown_entity();
        test_truncated_tail();
        test_random_text();
        test_output_hold_off();

        wait_drain();
        if (mismatch_count == 0 && expected_q.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- html_entity_decode_tag_strip.f -----
+incdir+design
design/hedts_pkg.sv
design/hedts_intf.sv
design/hedts_cell.sv
design/hedts_decide.sv
design/html_entity_decode_tag_strip.sv
bench/html_entity_decode_tag_strip_tb.sv
